@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, sampled on clk, off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge
`define ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// antecedent in one cycle implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent in one cycle implies consequent in the next cycle
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ sv/amq_pkg.sv @@
// ----------------------------------------------------------------------------
// amq_pkg
// types, codes and the ordering function of the absolute value min heap
// ----------------------------------------------------------------------------
`default_nettype none

package amq_pkg;

    typedef logic [1:0] status_t;

    localparam status_t ST_POPPED = 2'd0;
    localparam status_t ST_EMPTY  = 2'd1;
    localparam status_t ST_FULL   = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_POP_RD0,
        S_POP_LAST,
        S_DN_RDL,
        S_DN_RDR,
        S_DN_CMPR,
        S_DN_MOVE,
        S_EMIT
    } state_t;

    // true when a leaves the heap before b
    function automatic logic goes_first(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] mag_a;
        logic [31:0] mag_b;
        mag_a = a[31] ? (~a + 32'd1) : a;
        mag_b = b[31] ? (~b + 32'd1) : b;
        if (mag_a != mag_b)
        begin
            return mag_a < mag_b;
        end
        return $signed(a) < $signed(b);
    endfunction

endpackage

`default_nettype wire

@@ sv/abs_min_priority_queue_unit.sv @@
// ----------------------------------------------------------------------------
// abs_min_priority_queue_unit
// binary min heap ordered by absolute value, negative first on equal magnitude
//
// request channel: request_value with request_valid / request_stall. a nonzero
// value is pushed, zero pops the least element. result channel: popped_value
// and status with result_valid / result_stall. a successful push gives no
// result; a pop gives the element (status popped), or 0 with status empty;
// a push into a full heap is dropped and gives 0 with status full.
// the heap lives in one ram with a registered read, swept by one shared
// comparator. a push sifts the new value up from the new leaf toward the
// root; a pop reads the root and, unless it was the last element, sifts the
// last element down from the root; empty or full goes straight to the emit
// state. request_stall stays high while an item is at work.
// a finished result waits in the output register; the next request is taken
// meanwhile, and a later result waits in the emit state until the register
// frees up. reset empties the heap at once (count to zero) and drops any
// pending result; the ram itself is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module abs_min_priority_queue_unit #(
    parameter int CAPACITY = 1024
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               request_valid,
    output logic                    request_stall,
    input  wire logic signed [31:0] request_value,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output logic signed [31:0]      popped_value,
    output amq_pkg::status_t        status
);

    import amq_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = AW + 2;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [AW-1:0]   pos_reg, pos_next;
    logic [31:0]     val_reg, val_next;
    logic [31:0]     best_val_reg, best_val_next;
    logic [AW-1:0]   best_idx_reg, best_idx_next;
    logic            best_child_reg, best_child_next;
    logic [31:0]     res_value_reg, res_value_next;
    status_t         res_status_reg, res_status_next;
    logic            result_valid_reg;
    logic [31:0]     popped_value_reg;
    status_t         status_reg;

    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [31:0]     mem_wdata;
    logic [AW-1:0]   mem_raddr;
    logic [31:0]     mem_rdata;

    logic [LW-1:0]   left_idx;
    logic [LW-1:0]   right_idx;
    logic [LW-1:0]   count_ext;
    logic [AW-1:0]   pos_m1;
    logic [AW-1:0]   parent_idx;
    logic [31:0]     cmp_a;
    logic [31:0]     cmp_b;
    logic            cmp_first;
    logic            req_fire;
    logic            out_fire;
    logic            emit_fire;
    logic            in_sift;
    logic            push_ok;

    logic [31:0]     fin_val;
    logic [AW-1:0]   fin_idx;
    logic            fin_child;

    amq_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_heap_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign left_idx   = {1'b0, pos_reg, 1'b1};
    assign right_idx  = {1'b0, pos_reg, 1'b0} + LW'(2);
    assign count_ext  = LW'(count_reg);
    assign pos_m1     = pos_reg - 1'b1;
    assign parent_idx = pos_m1 >> 1;

    assign req_fire  = request_valid && !request_stall;
    assign out_fire  = result_valid_reg && !result_stall;
    assign emit_fire = (state_reg == S_EMIT) && (!result_valid_reg || !result_stall);

    // shared comparator operands
    always_comb
    begin
        cmp_a = mem_rdata;
        cmp_b = val_reg;
        unique case (state_reg)
            S_UP_CMP:
            begin
                cmp_a = val_reg;
                cmp_b = mem_rdata;
            end
            S_DN_CMPR:
            begin
                cmp_a = mem_rdata;
                cmp_b = best_val_reg;
            end
            default:
            begin
                cmp_a = mem_rdata;
                cmp_b = val_reg;
            end
        endcase
    end

    assign cmp_first = goes_first(cmp_a, cmp_b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (emit_fire)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (out_fire)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        val_reg        <= val_next;
        best_val_reg   <= best_val_next;
        best_idx_reg   <= best_idx_next;
        best_child_reg <= best_child_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        if (emit_fire)
        begin
            popped_value_reg <= res_value_reg;
            status_reg       <= res_status_reg;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        val_next        = val_reg;
        best_val_next   = best_val_reg;
        best_idx_next   = best_idx_reg;
        best_child_next = best_child_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        mem_we          = 1'b0;
        mem_waddr       = pos_reg;
        mem_wdata       = val_reg;
        mem_raddr       = '0;
        fin_val         = best_val_reg;
        fin_idx         = best_idx_reg;
        fin_child       = best_child_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    if (request_value != '0)
                    begin
                        if (count_reg == CW'(CAPACITY))
                        begin
                            res_value_next  = '0;
                            res_status_next = ST_FULL;
                            state_next      = S_EMIT;
                        end
                        else
                        begin
                            val_next   = request_value;
                            pos_next   = count_reg[AW-1:0];
                            count_next = count_reg + 1'b1;
                            state_next = S_UP_RD;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        res_value_next  = '0;
                        res_status_next = ST_EMPTY;
                        state_next      = S_EMIT;
                    end
                    else
                    begin
                        mem_raddr  = '0;
                        count_next = count_reg - 1'b1;
                        state_next = S_POP_RD0;
                    end
                end
            end

            // sift up: hole at pos, new value in val_reg
            S_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    mem_we     = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    mem_raddr  = parent_idx;
                    state_next = S_UP_CMP;
                end
            end

            S_UP_CMP:
            begin
                mem_we = 1'b1;
                if (cmp_first)
                begin
                    mem_wdata  = mem_rdata;
                    pos_next   = parent_idx;
                    state_next = S_UP_RD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            S_POP_RD0:
            begin
                res_value_next  = mem_rdata;
                res_status_next = ST_POPPED;
                mem_raddr       = count_reg[AW-1:0];
                if (count_reg == '0)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_POP_LAST;
                end
            end

            S_POP_LAST:
            begin
                val_next   = mem_rdata;
                pos_next   = '0;
                state_next = S_DN_RDL;
            end

            // sift down: hole at pos, moving value in val_reg
            S_DN_RDL:
            begin
                if (left_idx >= count_ext)
                begin
                    mem_we     = 1'b1;
                    state_next = S_EMIT;
                end
                else
                begin
                    mem_raddr  = left_idx[AW-1:0];
                    state_next = S_DN_RDR;
                end
            end

            S_DN_RDR:
            begin
                best_val_next   = cmp_first ? mem_rdata : val_reg;
                best_child_next = cmp_first;
                best_idx_next   = left_idx[AW-1:0];
                if (right_idx < count_ext)
                begin
                    mem_raddr  = right_idx[AW-1:0];
                    state_next = S_DN_CMPR;
                end
                else
                begin
                    state_next = S_DN_MOVE;
                end
            end

            S_DN_CMPR, S_DN_MOVE:
            begin
                if ((state_reg == S_DN_CMPR) && cmp_first)
                begin
                    fin_val   = mem_rdata;
                    fin_idx   = right_idx[AW-1:0];
                    fin_child = 1'b1;
                end
                mem_we = 1'b1;
                if (fin_child)
                begin
                    mem_wdata  = fin_val;
                    pos_next   = fin_idx;
                    state_next = S_DN_RDL;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end

            S_EMIT:
            begin
                if (emit_fire)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign request_stall = (state_reg != S_IDLE);
    assign result_valid  = result_valid_reg;
    assign popped_value  = popped_value_reg;
    assign status        = status_reg;

    assign in_sift = (state_reg == S_UP_RD) || (state_reg == S_UP_CMP)
                  || (state_reg == S_DN_RDL) || (state_reg == S_DN_RDR)
                  || (state_reg == S_DN_CMPR) || (state_reg == S_DN_MOVE);
    assign push_ok = req_fire && (request_value != '0) && (count_reg != CW'(CAPACITY));

    `ASSERT_ALWAYS(a_count_bound, count_reg <= CW'(CAPACITY))
    `ASSERT_IMPLIES(a_result_from_emit, $rose(result_valid_reg), $past(state_reg == S_EMIT))
    `ASSERT_IMPLIES(a_hole_in_heap, in_sift, LW'(pos_reg) < count_ext)
    `ASSERT_NEXT(a_push_counts, push_ok, count_reg == $past(count_reg) + 1'b1)

endmodule

`default_nettype wire

@@ sv/amq_ram.sv @@
// ----------------------------------------------------------------------------
// amq_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module amq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                                         clk,
    input  wire logic                                         we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                             wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire
